// File: rtl/rtdi_pkg.sv
// Package for the ready-to-drive interlock: item, result and register types,
// register indexes, signal codes and the saturating timer increment.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rtdi_pkg;

   // Timer and counter widths.
   localparam int TIMER_WIDTH  = 16;
   localparam int NUM_SIGNALS  = 4;
   localparam int SIG_W        = $clog2(NUM_SIGNALS);
   localparam int HORN_PULSES  = 3;
   localparam int HORN_W       = $clog2(HORN_PULSES + 1);
   localparam int PRESS_W      = 3;
   localparam int VALUE_W      = 16;
   localparam int REG_W        = 16;
   localparam int NUM_REGS     = 6;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 3;
   localparam int RSP_DATA_W   = 16;

   // Press counts that ask for a reboot or a power-off.
   localparam logic [PRESS_W-1:0] REBOOT_PRESSES   = PRESS_W'(3);
   localparam logic [PRESS_W-1:0] POWEROFF_PRESSES = PRESS_W'(5);

   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_NOTIFY = 1'b1
   } op_type;

   typedef enum logic [SIG_W-1:0] {
      SIG_BRAKE   = 2'd0,
      SIG_BUTTON  = 2'd1,
      SIG_SPEED   = 2'd2,
      SIG_VOLTAGE = 2'd3
   } signal_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_STALE_LIMIT = 3'd0,
      REG_MIN_VOLTAGE = 3'd1,
      REG_BLINK_HALF  = 3'd2,
      REG_WINDOW      = 3'd3,
      REG_HORN_ON     = 3'd4,
      REG_HORN_OFF    = 3'd5
   } reg_index_type;

   typedef struct packed {
      op_type               op;
      signal_type           signal_id;
      logic [VALUE_W-1:0]   signal_value;
   } item_type;

   typedef struct packed {
      logic [REG_W-1:0] stale_limit_ticks;
      logic [REG_W-1:0] min_voltage;
      logic [REG_W-1:0] blink_half_ticks;
      logic [REG_W-1:0] button_window_ticks;
      logic [REG_W-1:0] horn_on_ticks;
      logic [REG_W-1:0] horn_off_ticks;
   } cfg_type;

   typedef struct packed {
      logic             poweroff_request;
      logic             reboot_request;
      logic             horn;
      logic [SIG_W-1:0] fault_source;
      logic             fault;
      logic             ready_light;
      logic             unit_light;
      logic             drive_active;
   } result_type;

   // Timer increment that sticks at all ones.
   function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
      return (&v) ? v : v + TIMER_WIDTH'(1);
   endfunction

endpackage

`default_nettype wire

// File: rtl/rtdi_core.sv
// State and next-state logic of the ready-to-drive interlock: signal ages,
// blink, button window, horn sequence and drive latch, one word per step.
// Depends on rtdi_pkg.
`default_nettype none

module rtdi_core
   import rtdi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic [TIMER_WIDTH-1:0] age_ff [NUM_SIGNALS];
   logic [TIMER_WIDTH-1:0] age_in [NUM_SIGNALS];
   logic                   brake_ff, brake_in;
   logic                   button_ff, button_in;
   logic                   latched_ff, latched_in;
   logic [PRESS_W-1:0]     press_ff, press_in;
   logic [TIMER_WIDTH-1:0] window_timer_ff, window_timer_in;
   logic                   window_run_ff, window_run_in;
   logic [TIMER_WIDTH-1:0] blink_cnt_ff, blink_cnt_in;
   logic                   blink_phase_ff, blink_phase_in;
   logic [HORN_W-1:0]      horn_left_ff, horn_left_in;
   logic [TIMER_WIDTH-1:0] horn_timer_ff, horn_timer_in;
   logic                   horn_on_ff, horn_on_in;

   // Next state and the result of the word in the input register.
   always_comb begin
      logic             healthy;
      logic [SIG_W-1:0] src;
      logic             button_new;

      for (int i = 0; i < NUM_SIGNALS; i++) begin
         age_in[i] = age_ff[i];
      end
      brake_in        = brake_ff;
      button_in       = button_ff;
      latched_in      = latched_ff;
      press_in        = press_ff;
      window_timer_in = window_timer_ff;
      window_run_in   = window_run_ff;
      blink_cnt_in    = blink_cnt_ff;
      blink_phase_in  = blink_phase_ff;
      horn_left_in    = horn_left_ff;
      horn_timer_in   = horn_timer_ff;
      horn_on_in      = horn_on_ff;
      result          = '0;
      healthy         = 1'b1;
      src             = '0;
      button_new      = (item.signal_value != '0);

      if (item.op == OP_TICK) begin
         // Time passes: ages, blink, press window and horn sequence advance.
         for (int i = 0; i < NUM_SIGNALS; i++) begin
            age_in[i] = sat_inc(age_ff[i]);
         end

         blink_cnt_in = sat_inc(blink_cnt_ff);
         if (blink_cnt_in >= cfg.blink_half_ticks) begin
            blink_cnt_in   = '0;
            blink_phase_in = !blink_phase_ff;
         end

         if (window_run_ff) begin
            window_timer_in = sat_inc(window_timer_ff);
            if (window_timer_in >= cfg.button_window_ticks) begin
               if (press_ff >= POWEROFF_PRESSES) begin
                  result.poweroff_request = 1'b1;
               end else if (press_ff >= REBOOT_PRESSES) begin
                  result.reboot_request = 1'b1;
               end
               press_in        = '0;
               window_run_in   = 1'b0;
               window_timer_in = '0;
            end
         end

         if (horn_left_ff != '0) begin
            horn_timer_in = sat_inc(horn_timer_ff);
            if (horn_on_ff) begin
               if (horn_timer_in >= cfg.horn_on_ticks) begin
                  horn_on_in    = 1'b0;
                  horn_timer_in = '0;
               end
            end else if (horn_timer_in >= cfg.horn_off_ticks) begin
               horn_left_in  = horn_left_ff - HORN_W'(1);
               horn_timer_in = '0;
               horn_on_in    = (horn_left_in != '0);
            end
         end
      end else begin
         // A signal arrived: refresh its age and take its level.
         case (item.signal_id)
            SIG_BRAKE: begin
               brake_in  = button_new;
               age_in[0] = '0;
            end
            SIG_BUTTON: begin
               button_in = button_new;
               if (button_new) begin
                  if (!(&press_ff)) begin
                     press_in = press_ff + PRESS_W'(1);
                  end
                  window_timer_in = '0;
                  window_run_in   = 1'b1;
               end
               age_in[1] = '0;
            end
            SIG_SPEED: begin
               age_in[2] = '0;
            end
            default: begin
               if (item.signal_value >= cfg.min_voltage) begin
                  age_in[3] = '0;
               end
            end
         endcase
      end

      // The lowest numbered stale signal wins.
      for (int i = NUM_SIGNALS - 1; i >= 0; i--) begin
         if (age_in[i] > cfg.stale_limit_ticks) begin
            healthy = 1'b0;
            src     = SIG_W'(i);
         end
      end

      // Lights and the drive latch.
      if (healthy) begin
         result.unit_light = 1'b1;
         if (latched_ff) begin
            result.drive_active = 1'b1;
         end else if (brake_in) begin
            if (button_in) begin
               latched_in    = 1'b1;
               horn_left_in  = HORN_W'(HORN_PULSES);
               horn_timer_in = '0;
               horn_on_in    = 1'b1;
            end else begin
               result.ready_light = 1'b1;
            end
         end else begin
            result.ready_light = blink_phase_in;
         end
      end else begin
         latched_in          = 1'b0;
         result.unit_light   = blink_phase_in;
         result.fault        = 1'b1;
         result.fault_source = src;
      end
      result.horn = horn_on_in;
   end

   // State registers advance once per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SIGNALS; i++) begin
            age_ff[i] <= '1;
         end
         brake_ff        <= 1'b0;
         button_ff       <= 1'b0;
         latched_ff      <= 1'b0;
         press_ff        <= '0;
         window_timer_ff <= '0;
         window_run_ff   <= 1'b0;
         blink_cnt_ff    <= '0;
         blink_phase_ff  <= 1'b0;
         horn_left_ff    <= '0;
         horn_timer_ff   <= '0;
         horn_on_ff      <= 1'b0;
      end else if (step) begin
         for (int i = 0; i < NUM_SIGNALS; i++) begin
            age_ff[i] <= age_in[i];
         end
         brake_ff        <= brake_in;
         button_ff       <= button_in;
         latched_ff      <= latched_in;
         press_ff        <= press_in;
         window_timer_ff <= window_timer_in;
         window_run_ff   <= window_run_in;
         blink_cnt_ff    <= blink_cnt_in;
         blink_phase_ff  <= blink_phase_in;
         horn_left_ff    <= horn_left_in;
         horn_timer_ff   <= horn_timer_in;
         horn_on_ff      <= horn_on_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ready_to_drive_interlock.sv
// Top level of the ready-to-drive interlock: stream channels, input and
// result registers, and the register file. Depends on rtdi_pkg and rtdi_core.
//
// Usage: each word on the req_ channel is either one time tick (req_tuser
// bit 0 low) or a notification of one signal (bit 0 high, signal code in
// req_tuser[2:1], value in req_tdata). Every accepted word yields exactly
// one result word on the rsp_ channel, in order.
// Order: the state update and result are formed while the word sits in the
// input register and are written to the result register when that register
// is empty or its word is taken.
// Throughput: one word per cycle while rsp_tready stays high, set by the single
// state update pass between the input register and the result register.
// Stall: when rsp_tready is low the result register holds; the input
// register still takes one more word, and req_tready drops after that.
// Reset: synchronous. All four signals start stale, the latch, counters,
// horn and lights clear, and the registers return to their defaults.
// Registers sit at byte addresses 0x00 to 0x14 on the csr_ port; the user must
// make writes only while no word is in flight; the block does not enforce it.
`default_nettype none

module ready_to_drive_interlock
   import rtdi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [VALUE_W-1:0]    req_tdata,   // [15:0] signal_value
   input  wire logic [2:0]            req_tuser,   // [0] op, [2:1] signal_id
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [0] drive_active,
   // [1] unit_light, [2] ready_light, [3] fault, [5:4] fault_source,
   // [6] horn, [7] reboot_request, [8] poweroff_request, [15:9] zero
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type result_ff;
   result_type result_next;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_fire;
   logic       csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   // Pipeline control: the result register moves when empty or taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign item_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = advance ? item_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.op           <= op_type'(req_tuser[0]);
         item_ff.signal_id    <= signal_type'(req_tuser[2:1]);
         item_ff.signal_value <= req_tdata;
      end
      if (advance && item_valid_ff) begin
         result_ff <= result_next;
      end
   end

   rtdi_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance && item_valid_ff),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(result_ff);

   // Register file: written in the access phase, read back at any time.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stale_limit_ticks   <= REG_W'(100);
         cfg_ff.min_voltage         <= REG_W'(250);
         cfg_ff.blink_half_ticks    <= REG_W'(500);
         cfg_ff.button_window_ticks <= REG_W'(1000);
         cfg_ff.horn_on_ticks       <= REG_W'(300);
         cfg_ff.horn_off_ticks      <= REG_W'(150);
      end else if (csr_write) begin
         case (csr_index)
            REG_STALE_LIMIT: cfg_ff.stale_limit_ticks   <= csr_pwdata[REG_W-1:0];
            REG_MIN_VOLTAGE: cfg_ff.min_voltage         <= csr_pwdata[REG_W-1:0];
            REG_BLINK_HALF:  cfg_ff.blink_half_ticks    <= csr_pwdata[REG_W-1:0];
            REG_WINDOW:      cfg_ff.button_window_ticks <= csr_pwdata[REG_W-1:0];
            REG_HORN_ON:     cfg_ff.horn_on_ticks       <= csr_pwdata[REG_W-1:0];
            REG_HORN_OFF:    cfg_ff.horn_off_ticks      <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_STALE_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.stale_limit_ticks);
         REG_MIN_VOLTAGE: csr_prdata = CSR_DATA_W'(cfg_ff.min_voltage);
         REG_BLINK_HALF:  csr_prdata = CSR_DATA_W'(cfg_ff.blink_half_ticks);
         REG_WINDOW:      csr_prdata = CSR_DATA_W'(cfg_ff.button_window_ticks);
         REG_HORN_ON:     csr_prdata = CSR_DATA_W'(cfg_ff.horn_on_ticks);
         REG_HORN_OFF:    csr_prdata = CSR_DATA_W'(cfg_ff.horn_off_ticks);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/rtdi_checker.sv
// Port-level checks for the ready-to-drive interlock, bound to the top level.
// Depends on rtdi_pkg and ready_to_drive_interlock.
`default_nettype none

module rtdi_checker
   import rtdi_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A held result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Drive is only reported with a lit unit light and no fault.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1] && !rsp_tdata[3])
      else $error("drive active during a fault");

   // The fault source is zero when no fault is reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[5:4] == 2'd0)
      else $error("fault source without a fault");

   // Reboot and power-off never come in the same word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[7] && rsp_tdata[8]))
      else $error("reboot and power-off both requested");

   // A word taken while the result side is stalled shows up as ready low next
   // cycle unless the stall has ended, since only one word may wait behind the result register.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=>
         !(rsp_tvalid && !rsp_tready) || !req_tready)
      else $error("input accepted with no room behind stalled result");

endmodule

bind ready_to_drive_interlock rtdi_checker u_rtdi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
